FILE: sv/splim_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package splim_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_ENABLE   = 3'd0;
    localparam logic [2:0] CFG_CHANNELS = 3'd1;
    localparam logic [2:0] CFG_CEILING  = 3'd2;
    localparam logic [2:0] CFG_STRENGTH = 3'd3;
    localparam logic [2:0] CFG_RELEASE  = 3'd4;

    // Fixed-format constants
    localparam int          COEFF_BITS      = 24;
    localparam int          STRENGTH_BITS   = 17;
    localparam int          STRENGTH_FRAC   = 16;
    localparam logic [16:0] STRENGTH_FULL   = 17'd65536;
    localparam logic [23:0] RELEASE_RESET   = 24'd16774300;
    localparam logic [63:0] CEIL_RESET_Q24  = 64'd15790320;
    localparam logic [1:0]  CHANNELS_RESET  = 2'd2;
    localparam logic [1:0]  CHANNELS_MONO   = 2'd1;

    // Shared multiplier operand selection
    typedef enum logic [2:0] {
        MSEL_PG,
        MSEL_REL,
        MSEL_STR,
        MSEL_LEFT,
        MSEL_RIGHT
    } mul_sel_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PEAK,
        ST_MUL_PG,
        ST_CMP,
        ST_DIV,
        ST_ATT,
        ST_MUL_REL,
        ST_REL,
        ST_MUL_STR,
        ST_STR,
        ST_MUL_L,
        ST_MUL_R,
        ST_SCL_R,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic     load_in;
        logic     load_peak;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     cmp_en;
        logic     div_step;
        logic     att_upd;
        logic     rel_upd;
        logic     str_upd;
        logic     store_l;
        logic     store_r;
        logic     out_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic enable;
        logic over_ceiling;
        logic div_last;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/splim_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module splim_ctrl
    import splim_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // output slot can take a new frame when empty or being drained
    assign slot_free = !out_valid_reg || out_ready;

    // state and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = status.enable ? ST_PEAK : ST_FINISH;
            end
            ST_PEAK:    state_next = ST_MUL_PG;
            ST_MUL_PG:  state_next = ST_CMP;
            ST_CMP:     state_next = status.over_ceiling ? ST_DIV : ST_MUL_REL;
            ST_DIV:
            begin
                if (status.div_last)
                    state_next = ST_ATT;
            end
            ST_ATT:     state_next = ST_MUL_STR;
            ST_MUL_REL: state_next = ST_REL;
            ST_REL:     state_next = ST_MUL_STR;
            ST_MUL_STR: state_next = ST_STR;
            ST_STR:     state_next = ST_MUL_L;
            ST_MUL_L:   state_next = ST_MUL_R;
            ST_MUL_R:   state_next = ST_SCL_R;
            ST_SCL_R:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MSEL_PG;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_PEAK:    cmd.load_peak = 1'b1;
            ST_MUL_PG:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_PG;
            end
            ST_CMP:     cmd.cmp_en = 1'b1;
            ST_DIV:     cmd.div_step = 1'b1;
            ST_ATT:     cmd.att_upd = 1'b1;
            ST_MUL_REL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_REL;
            end
            ST_REL:     cmd.rel_upd = 1'b1;
            ST_MUL_STR:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_STR;
            end
            ST_STR:     cmd.str_upd = 1'b1;
            ST_MUL_L:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_LEFT;
            end
            ST_MUL_R:
            begin
                cmd.store_l = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_RIGHT;
            end
            ST_SCL_R:   cmd.store_r = 1'b1;
            ST_FINISH:  cmd.out_load = slot_free;
            default:    cmd = '0;
        endcase
    end

    // result valid: set on load, cleared on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: sv/splim_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module splim_dp
    import splim_pkg::*;
#(
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 24,
    parameter int CFG_BITS       = 25
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire dp_cmd_t                          cmd,
    output dp_status_t                            status,
    input  wire logic                             cfg_we,
    input  wire logic [2:0]                       cfg_index,
    input  wire logic [CFG_BITS-1:0]              cfg_data,
    input  wire logic signed [SAMPLE_BITS-1:0]    left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]    right_sample,
    output logic signed [SAMPLE_BITS-1:0]         left_out,
    output logic signed [SAMPLE_BITS-1:0]         right_out,
    output logic [GAIN_FRAC_BITS:0]               applied_gain,
    output logic                                  attack_taken
);

    localparam int GW     = GAIN_FRAC_BITS + 1;
    localparam int SFRAC  = SAMPLE_BITS - 2;
    localparam int LW     = GW + SFRAC;
    localparam int DW     = SAMPLE_BITS + GAIN_FRAC_BITS;
    localparam int MA     = ((SAMPLE_BITS > COEFF_BITS) ? SAMPLE_BITS : COEFF_BITS) + 1;
    localparam int MB     = GW + 1;
    localparam int PW     = MA + MB;
    localparam int CNTW   = $clog2(GW);
    localparam int CEIL_UP = (GAIN_FRAC_BITS >= 24) ? GAIN_FRAC_BITS - 24 : 0;
    localparam int CEIL_DN = (GAIN_FRAC_BITS < 24) ? 24 - GAIN_FRAC_BITS : 0;

    localparam logic [63:0]           CEIL_RESET_W = (CEIL_RESET_Q24 << CEIL_UP) >> CEIL_DN;
    localparam logic [GW-1:0]         CEIL_RESET   = CEIL_RESET_W[GW-1:0];
    localparam logic [GW-1:0]         GAIN_ONE     = GW'(1) << GAIN_FRAC_BITS;
    localparam logic signed [PW-1:0]  HALF_GAIN    = PW'(1) << (GAIN_FRAC_BITS - 1);
    localparam logic signed [PW-1:0]  HALF_STR     = PW'(1) << (STRENGTH_FRAC - 1);
    localparam logic signed [PW-1:0]  SAMP_MAX_W   = (PW'(1) << (SAMPLE_BITS - 1)) - PW'(1);
    localparam logic signed [PW-1:0]  SAMP_MIN_W   = -SAMP_MAX_W - PW'(1);

    // configuration registers
    logic                     enable_reg;
    logic [1:0]               channels_reg;
    logic [GW-1:0]            ceiling_reg;
    logic [STRENGTH_BITS-1:0] strength_reg;
    logic [COEFF_BITS-1:0]    coeff_reg;

    // frame and working registers
    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic signed [SAMPLE_BITS-1:0] right_reg;
    logic [SAMPLE_BITS-1:0]        peak_reg;
    logic [GW-1:0]                 gain_reg;
    logic [GW-1:0]                 gain_next;
    logic [GW-1:0]                 limit_gain_reg;
    logic [GW-1:0]                 applied_reg;
    logic                          attack_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [SAMPLE_BITS-1:0] left_res_reg;
    logic signed [SAMPLE_BITS-1:0] right_res_reg;

    // divider registers
    logic [LW-1:0]   rem_reg;
    logic [DW-1:0]   dsr_reg;
    logic [GW-1:0]   quo_reg;
    logic [CNTW-1:0] cnt_reg;

    // output registers
    logic signed [SAMPLE_BITS-1:0] left_out_reg;
    logic signed [SAMPLE_BITS-1:0] right_out_reg;
    logic [GW-1:0]                 applied_out_reg;
    logic                          attack_out_reg;

    logic                          mono;
    logic [SAMPLE_BITS-1:0]        mag_l;
    logic [SAMPLE_BITS-1:0]        mag_r;
    logic [SAMPLE_BITS-1:0]        peak_next;
    logic [LW-1:0]                 limit;
    logic [STRENGTH_BITS-1:0]      strength_sat;
    logic [GW-1:0]                 headroom;
    logic signed [MA-1:0]          op_a;
    logic signed [MB-1:0]          op_b;
    logic signed [PW-1:0]          prod_str_rnd;
    logic signed [PW-1:0]          scaled;
    logic signed [SAMPLE_BITS-1:0] scaled_sat;
    logic [DW-1:0]                 rem_ext;
    logic                          div_fits;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b1;
            channels_reg <= CHANNELS_RESET;
            ceiling_reg  <= CEIL_RESET;
            strength_reg <= STRENGTH_FULL;
            coeff_reg    <= RELEASE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:   enable_reg   <= cfg_data[0];
                CFG_CHANNELS: channels_reg <= cfg_data[1:0];
                CFG_CEILING:  ceiling_reg  <= cfg_data[GW-1:0];
                CFG_STRENGTH: strength_reg <= cfg_data[STRENGTH_BITS-1:0];
                CFG_RELEASE:  coeff_reg    <= cfg_data[COEFF_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // limiter gain state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_gain_reg <= GAIN_ONE;
        else if (cmd.att_upd || cmd.rel_upd)
            limit_gain_reg <= gain_next;
    end

    // peak detection
    assign mono      = (channels_reg == CHANNELS_MONO);
    assign mag_l     = left_reg[SAMPLE_BITS-1] ? (~left_reg + 1'b1) : left_reg;
    assign mag_r     = right_reg[SAMPLE_BITS-1] ? (~right_reg + 1'b1) : right_reg;
    assign peak_next = (!mono && (mag_r > mag_l)) ? mag_r : mag_l;
    assign limit     = {ceiling_reg, {SFRAC{1'b0}}};

    assign strength_sat = (strength_reg > STRENGTH_FULL) ? STRENGTH_FULL : strength_reg;
    assign headroom     = GAIN_ONE - gain_reg;

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MSEL_PG:
            begin
                op_a = signed'(MA'(peak_reg));
                op_b = signed'(MB'(gain_reg));
            end
            MSEL_REL:
            begin
                op_a = signed'(MA'(coeff_reg));
                op_b = signed'(MB'(headroom));
            end
            MSEL_STR:
            begin
                op_a = signed'(MA'(strength_sat));
                op_b = signed'(MB'(headroom));
            end
            MSEL_LEFT:
            begin
                op_a = MA'(left_reg);
                op_b = signed'(MB'(applied_reg));
            end
            MSEL_RIGHT:
            begin
                op_a = MA'(right_reg);
                op_b = signed'(MB'(applied_reg));
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // gain update: attack quotient or exponential release
    assign gain_next = cmd.att_upd ? quo_reg : (GAIN_ONE - prod_reg[COEFF_BITS +: GW]);

    // strength blend rounding
    assign prod_str_rnd = prod_reg + HALF_STR;

    // sample scaling: round half up, then saturate
    assign scaled = (prod_reg + HALF_GAIN) >>> GAIN_FRAC_BITS;
    always_comb
    begin
        if (scaled > SAMP_MAX_W)
            scaled_sat = SAMP_MAX_W[SAMPLE_BITS-1:0];
        else if (scaled < SAMP_MIN_W)
            scaled_sat = SAMP_MIN_W[SAMPLE_BITS-1:0];
        else
            scaled_sat = scaled[SAMPLE_BITS-1:0];
    end

    // restoring divider, one quotient bit per cycle
    assign rem_ext  = DW'(rem_reg);
    assign div_fits = (rem_ext >= dsr_reg);

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            left_reg  <= left_sample;
            right_reg <= right_sample;
        end
        if (cmd.load_peak)
        begin
            peak_reg <= peak_next;
            gain_reg <= (limit_gain_reg > GAIN_ONE) ? GAIN_ONE : limit_gain_reg;
        end
        if (cmd.mul_en)
            prod_reg <= op_a * op_b;
        if (cmd.cmp_en)
        begin
            attack_reg <= status.over_ceiling;
            rem_reg    <= limit;
            dsr_reg    <= {peak_reg, {GAIN_FRAC_BITS{1'b0}}};
            quo_reg    <= '0;
            cnt_reg    <= CNTW'(GAIN_FRAC_BITS);
        end
        if (cmd.div_step)
        begin
            if (div_fits)
                rem_reg <= rem_reg - dsr_reg[LW-1:0];
            quo_reg <= {quo_reg[GW-2:0], div_fits};
            dsr_reg <= dsr_reg >> 1;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.att_upd || cmd.rel_upd)
            gain_reg <= gain_next;
        if (cmd.str_upd)
            applied_reg <= GAIN_ONE - prod_str_rnd[STRENGTH_FRAC +: GW];
        if (cmd.store_l)
            left_res_reg <= scaled_sat;
        if (cmd.store_r)
            right_res_reg <= scaled_sat;
    end

    // output register, bypass and mono selection
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (!enable_reg)
            begin
                left_out_reg    <= left_reg;
                right_out_reg   <= right_reg;
                applied_out_reg <= GAIN_ONE;
                attack_out_reg  <= 1'b0;
            end
            else
            begin
                left_out_reg    <= left_res_reg;
                right_out_reg   <= mono ? right_reg : right_res_reg;
                applied_out_reg <= applied_reg;
                attack_out_reg  <= attack_reg;
            end
        end
    end

    assign status.enable       = enable_reg;
    assign status.over_ceiling = ($unsigned(prod_reg) > PW'(limit));
    assign status.div_last     = (cnt_reg == '0);

    assign left_out     = left_out_reg;
    assign right_out    = right_out_reg;
    assign applied_gain = applied_out_reg;
    assign attack_taken = attack_out_reg;

endmodule

`default_nettype wire

FILE: sv/stereo_peak_limiter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Stereo peak limiter: instant attack, exponential release.
// Input channel: in_valid/in_ready carry one stereo frame (left_sample,
// right_sample). Output channel: out_valid/out_ready carry left_out,
// right_out, applied_gain and attack_taken. Register writes use
// cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
// One frame is processed at a time by a sequencer around one shared
// multiplier and a restoring divider; the divider yields one quotient bit
// per cycle and runs only on attack, while release uses the multiplier.
// Bypass frames skip from idle straight to the finish state.
// in_ready rises together with out_valid, so the next frame can be taken
// while the result is first offered on the output channel.
// The result sits in an output register; the next frame is taken and
// processed while it waits, and a finished frame holds until the output
// slot frees. A stalled receiver thus stalls input after one further frame.
// Reset restores register defaults (limiting on, stereo, ceiling about -0.53 dB,
// full strength) and a limiter gain of 1.0; no result is pending.

module stereo_peak_limiter_top
    import splim_pkg::*;
#(
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 24
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]         left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]         right_sample,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [SAMPLE_BITS-1:0]              left_out,
    output logic signed [SAMPLE_BITS-1:0]              right_out,
    output logic [GAIN_FRAC_BITS:0]                    applied_gain,
    output logic                                       attack_taken,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [2:0]                            cfg_index,
    input  wire logic [((GAIN_FRAC_BITS >= COEFF_BITS) ? GAIN_FRAC_BITS + 1 : COEFF_BITS)-1:0]
                                                       cfg_data
);

    localparam int CFG_BITS = (GAIN_FRAC_BITS >= COEFF_BITS) ? GAIN_FRAC_BITS + 1 : COEFF_BITS;

    dp_cmd_t    cmd;
    dp_status_t status;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    splim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    splim_dp #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .CFG_BITS       (CFG_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .left_out     (left_out),
        .right_out    (right_out),
        .applied_gain (applied_gain),
        .attack_taken (attack_taken)
    );

endmodule

`default_nettype wire

FILE: sv/splim_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module splim_checker #(
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 24
)
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [SAMPLE_BITS-1:0]        left_out,
    input wire logic [SAMPLE_BITS-1:0]        right_out,
    input wire logic [GAIN_FRAC_BITS:0]       applied_gain,
    input wire logic                          attack_taken
);

    localparam logic [GAIN_FRAC_BITS:0] GAIN_ONE = (GAIN_FRAC_BITS + 1)'(1) << GAIN_FRAC_BITS;

    // one frame in flight: input closes after each transfer
    property p_one_in_flight;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready;
    endproperty
    a_one_in_flight: assert property (p_one_in_flight)
        else $error("input accepted on consecutive cycles");

    // gain never boosts
    property p_gain_bound;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (applied_gain <= GAIN_ONE);
    endproperty
    a_gain_bound: assert property (p_gain_bound)
        else $error("applied gain above unity");

    // a stalled result holds
    property p_result_hold;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(left_out) && $stable(right_out)
            && $stable(applied_gain) && $stable(attack_taken));
    endproperty
    a_result_hold: assert property (p_result_hold)
        else $error("stalled result changed");

endmodule

bind stereo_peak_limiter_top splim_checker #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
) u_splim_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .left_out     (left_out),
    .right_out    (right_out),
    .applied_gain (applied_gain),
    .attack_taken (attack_taken)
);

`default_nettype wire

FILE: tb/stereo_peak_limiter_top_test.sv
`timescale 1ns / 1ps

module stereo_peak_limiter_top_test;
    import splim_pkg::*;

    localparam int              SAMPLE_BITS    = 24;
    localparam int              GAIN_FRAC_BITS = 24;
    localparam int              SAMPLE_FRAC    = SAMPLE_BITS - 2;
    localparam longint unsigned GAIN_ONE       = 64'd1 << GAIN_FRAC_BITS;
    localparam longint          ROUND_HALF     = 64'sd1 <<< (GAIN_FRAC_BITS - 1);
    localparam longint          SAMP_MAX       = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint          SAMP_MIN       = -SAMP_MAX - 1;
    localparam int              RANDOM_FRAMES  = 1100;
    localparam int              REPORT_LINES   = 50;

    // One limited frame as the block should present it
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic [GAIN_FRAC_BITS:0]       gain;
        logic                          attack;
    } frame_result_t;

    // Limiter model with its own register copy and gain state
    class limiter_scoreboard;
        bit                      enable;
        bit [1:0]                channels;
        bit [GAIN_FRAC_BITS:0]   ceiling;
        bit [16:0]               strength;
        bit [23:0]               release_coeff;
        bit [GAIN_FRAC_BITS:0]   limit_gain;
        frame_result_t           pending_frames[$];
        int                      mismatches;
        int                      frames_checked;

        function new();
            enable         = 1'b1;
            channels       = CHANNELS_RESET;
            ceiling        = 25'(CEIL_RESET_Q24);
            strength       = STRENGTH_FULL;
            release_coeff  = RELEASE_RESET;
            limit_gain     = 25'(GAIN_ONE);
            mismatches     = 0;
            frames_checked = 0;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= REPORT_LINES)
                $display("ERROR result %0d: %s", frames_checked, what);
        endtask

        function void set_reg(logic [2:0] idx, logic [GAIN_FRAC_BITS:0] data);
            case (idx)
                CFG_ENABLE:   enable        = data[0];
                CFG_CHANNELS: channels      = data[1:0];
                CFG_CEILING:  ceiling       = data[GAIN_FRAC_BITS:0];
                CFG_STRENGTH: strength      = data[16:0];
                CFG_RELEASE:  release_coeff = data[23:0];
                default: ;
            endcase
        endfunction

        // sample * gain, rounded half up, saturated
        function logic signed [SAMPLE_BITS-1:0] scale_sample(longint s, longint unsigned g);
            longint p;
            p = (s * longint'(g) + ROUND_HALF) >>> GAIN_FRAC_BITS;
            if (p > SAMP_MAX)
                p = SAMP_MAX;
            if (p < SAMP_MIN)
                p = SAMP_MIN;
            return SAMPLE_BITS'(p);
        endfunction

        function frame_result_t predict_frame(logic signed [SAMPLE_BITS-1:0] l,
                                              logic signed [SAMPLE_BITS-1:0] r);
            longint          sl, sr;
            longint unsigned peak, mag_r, gain, lim, req, str_sat, red, applied;
            bit              mono;
            frame_result_t   res;
            sl         = l;
            sr         = r;
            res.attack = 1'b0;
            // bypass: pass through, gain state untouched
            if (!enable) begin
                res.left  = l;
                res.right = r;
                res.gain  = 25'(GAIN_ONE);
                return res;
            end
            mono  = (channels == CHANNELS_MONO);
            peak  = (sl < 0) ? -sl : sl;
            mag_r = (sr < 0) ? -sr : sr;
            if (!mono && mag_r > peak)
                peak = mag_r;
            gain = (limit_gain > GAIN_ONE) ? GAIN_ONE : 64'(limit_gain);
            lim  = 64'(ceiling) << SAMPLE_FRAC;
            // instant attack, otherwise exponential release towards unity
            if (peak * gain > lim) begin
                req        = lim / ((peak == 0) ? 64'd1 : peak);
                res.attack = 1'b1;
                if (req < gain)
                    gain = req;
            end
            else begin
                gain = GAIN_ONE - ((64'(release_coeff) * (GAIN_ONE - gain)) >> COEFF_BITS);
            end
            limit_gain = 25'(gain);
            // blend by strength, rounded half up
            str_sat = (strength > STRENGTH_FULL) ? 64'(STRENGTH_FULL) : 64'(strength);
            red     = (str_sat * (GAIN_ONE - gain) + 64'd32768) >> STRENGTH_FRAC;
            applied = GAIN_ONE - red;
            res.left  = scale_sample(sl, applied);
            res.right = mono ? r : scale_sample(sr, applied);
            res.gain  = 25'(applied);
            return res;
        endfunction

        function void note_frame(logic signed [SAMPLE_BITS-1:0] l,
                                 logic signed [SAMPLE_BITS-1:0] r);
            pending_frames.push_back(predict_frame(l, r));
        endfunction

        task check_frame(logic signed [SAMPLE_BITS-1:0] lo, logic signed [SAMPLE_BITS-1:0] ro,
                         logic [GAIN_FRAC_BITS:0] ag, logic at);
            frame_result_t want;
            if (pending_frames.size() == 0) begin
                report_mismatch("result transfer with no frame pending");
                return;
            end
            want = pending_frames.pop_front();
            if (lo !== want.left)
                report_mismatch($sformatf("left_out %0d, expected %0d", lo, want.left));
            if (ro !== want.right)
                report_mismatch($sformatf("right_out %0d, expected %0d", ro, want.right));
            if (ag !== want.gain)
                report_mismatch($sformatf("applied_gain %0d, expected %0d", ag, want.gain));
            if (at !== want.attack)
                report_mismatch($sformatf("attack_taken %0b, expected %0b", at, want.attack));
            frames_checked++;
        endtask
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [GAIN_FRAC_BITS:0]       applied_gain;
    logic                          attack_taken;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [2:0]                    cfg_index;
    logic [GAIN_FRAC_BITS:0]       cfg_data;

    limiter_scoreboard sb = new();

    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;
    int seg_style  = 0;
    int seg_left   = 0;

    stereo_peak_limiter_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .left_out     (left_out),
        .right_out    (right_out),
        .applied_gain (applied_gain),
        .attack_taken (attack_taken),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver back-pressure: free-running, throttled, long stalls, periodic
    always @(negedge clk)
    begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(1, 60);
        end
        stall_left--;
        case (stall_mode)
            0:       out_ready = 1'b1;
            1:       out_ready = 1'($urandom_range(0, 1));
            2:       out_ready = 1'b0;
            default: out_ready = (stall_left % 3 != 0);
        endcase
    end

    // Observe transfers on all three channels
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_frame(left_out, right_out, applied_gain, attack_taken);
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_frame(left_sample, right_sample);
        end
    end

    // One frame transfer; bursts with random gaps between them
    task send_frame(logic signed [SAMPLE_BITS-1:0] l, logic signed [SAMPLE_BITS-1:0] r);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid     = 1'b1;
        left_sample  = l;
        right_sample = r;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        burst_left--;
    endtask

    // Hold off the sender until every frame has come back
    task wait_drained();
        in_valid = 1'b0;
        while (sb.pending_frames.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task write_reg(logic [2:0] idx, logic [GAIN_FRAC_BITS:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task apply_config(bit en, bit [1:0] ch, bit [GAIN_FRAC_BITS:0] ceil_val,
                      bit [16:0] str, bit [23:0] rel);
        write_reg(CFG_ENABLE, 25'(en));
        write_reg(CFG_CHANNELS, 25'(ch));
        write_reg(CFG_CEILING, ceil_val);
        write_reg(CFG_STRENGTH, 25'(str));
        write_reg(CFG_RELEASE, 25'(rel));
        cfg_valid = 1'b0;
    endtask

    // Random register set, weighted towards the extremes
    task random_config();
        bit                    en;
        bit [1:0]              ch;
        bit [GAIN_FRAC_BITS:0] ceil_val;
        bit [16:0]             str;
        bit [23:0]             rel;
        int                    pick;
        en   = ($urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 9);
        ch   = (pick < 5) ? 2'd2 : (pick < 8) ? CHANNELS_MONO : (pick == 8) ? 2'd0 : 2'd3;
        case ($urandom_range(0, 5))
            0:       ceil_val = 25'd0;
            1:       ceil_val = 25'(GAIN_ONE);
            2:       ceil_val = 25'($urandom_range(1, 16777216));
            3:       ceil_val = 25'($urandom_range(8388608, 16777216));
            4:       ceil_val = 25'($urandom_range(0, 1 << 20));
            default: ceil_val = 25'(CEIL_RESET_Q24);
        endcase
        case ($urandom_range(0, 6))
            0:       str = 17'd0;
            1, 2:    str = STRENGTH_FULL;
            3:       str = 17'($urandom_range(65537, 131071));
            default: str = 17'($urandom_range(0, 65536));
        endcase
        case ($urandom_range(0, 5))
            0:       rel = 24'd0;
            1:       rel = 24'hFFFFFF;
            2:       rel = 24'($urandom_range(16700000, 16777215));
            3:       rel = RELEASE_RESET;
            default: rel = 24'($urandom);
        endcase
        apply_config(en, ch, ceil_val, str, rel);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int style);
        int v;
        case (style)
            0: v = int'($urandom);
            1: v = int'($urandom_range(0, 4000)) - 2000;
            2: begin
                v = 8388607 - int'($urandom_range(0, 20000));
                if ($urandom_range(0, 1) != 0)
                    v = -v - 1;
            end
            3: begin
                case ($urandom_range(0, 4))
                    0:       v = -8388608;
                    1:       v = 8388607;
                    2:       v = 0;
                    3:       v = -1;
                    default: v = 1;
                endcase
            end
            default: v = int'($urandom_range(0, 4194304)) - 2097152;
        endcase
        return SAMPLE_BITS'(v);
    endfunction

    initial
    begin
        int                            sent;
        int                            phase_len;
        logic signed [SAMPLE_BITS-1:0] l;
        logic signed [SAMPLE_BITS-1:0] r;
        in_valid     = 1'b0;
        left_sample  = '0;
        right_sample = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_ENABLE;
        cfg_data     = '0;
        rst_n        = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(negedge clk);

        // Reset defaults: attacks on either channel at full scale, then release
        send_frame(24'sd0, 24'sd0);
        send_frame(24'sd8388607, 24'sd0);
        send_frame(-24'sd8388608, 24'sd5);
        send_frame(24'sd0, -24'sd8388608);
        send_frame(24'sd100, -24'sd100);
        send_frame(24'sd8388607, 24'sd8388607);
        wait_drained();

        // Bypass
        apply_config(1'b0, 2'd2, 25'(CEIL_RESET_Q24), STRENGTH_FULL, RELEASE_RESET);
        send_frame(-24'sd8388608, 24'sd8388607);
        send_frame(24'sd1234, -24'sd1);
        wait_drained();

        // Mono, unity ceiling, strength above full, instant release
        apply_config(1'b1, CHANNELS_MONO, 25'(GAIN_ONE), 17'h1FFFF, 24'd0);
        send_frame(24'sd0, -24'sd8388608);
        send_frame(-24'sd8388608, 24'sd8388607);
        send_frame(24'sd1, 24'sd1);
        wait_drained();

        // Zero ceiling, zero strength, slowest release; zero peak
        apply_config(1'b1, 2'd0, 25'd0, 17'd0, 24'hFFFFFF);
        send_frame(24'sd1, 24'sd0);
        send_frame(24'sd0, 24'sd0);
        send_frame(-24'sd1, 24'sd0);
        wait_drained();

        // Ceiling above one, half strength, mid release
        apply_config(1'b1, 2'd3, 25'h1FFFFFF, 17'd32768, 24'h800000);
        send_frame(-24'sd8388608, 24'sd0);
        send_frame(24'sd8388607, -24'sd8388607);
        send_frame(24'sd0, 24'sd0);
        send_frame(24'sd0, -24'sd8388608);

        // Random phases, each under a fresh register set
        sent = 0;
        while (sent < RANDOM_FRAMES) begin
            wait_drained();
            random_config();
            phase_len = $urandom_range(60, 140);
            repeat (phase_len) begin
                // signal segments: loud runs, quiet runs for release, extremes
                if (seg_left == 0) begin
                    seg_style = $urandom_range(0, 4);
                    seg_left  = $urandom_range(1, 30);
                end
                seg_left--;
                l = pick_sample(seg_style);
                r = ($urandom_range(0, 3) == 0) ? pick_sample($urandom_range(0, 4))
                                                : pick_sample(seg_style);
                send_frame(l, r);
                sent++;
                if ($urandom_range(0, 59) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (60) @(negedge clk);
        if (sb.mismatches == 0)
            $display("stereo_peak_limiter_top_test OK");
        else
            $display("stereo_peak_limiter_top_test NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("stereo_peak_limiter_top_test NOT OK");
        $finish;
    end

endmodule

FILE: stereo_peak_limiter_top.f
sv/splim_pkg.sv
sv/splim_ctrl.sv
sv/splim_dp.sv
sv/stereo_peak_limiter_top.sv
sv/splim_checker.sv
tb/stereo_peak_limiter_top_test.sv
